// ----- hw/rtl/stable_priority_queue_with_remove_assert.svh -----
// ----------------------------------------------------------------------------
// stable_priority_queue_with_remove_assert.svh
// Assertion macros shared by the queue checker.
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_WITH_REMOVE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_WITH_REMOVE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define SPQR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define SPQR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/spqr_pkg.sv -----
// ----------------------------------------------------------------------------
// spqr_pkg
// Request and status codes, controller/datapath interface types.
// ----------------------------------------------------------------------------
package spqr_pkg;

  localparam logic [1:0] REQ_ENQ = 2'd0;
  localparam logic [1:0] REQ_DEQ = 2'd1;
  localparam logic [1:0] REQ_REM = 2'd2;

  localparam logic [2:0] ST_QUEUED   = 3'd0;
  localparam logic [2:0] ST_DEQUEUED = 3'd1;
  localparam logic [2:0] ST_REMOVED  = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;
  localparam logic [2:0] ST_INVALID  = 3'd6;

  typedef struct packed {
    logic       load;
    logic       init_enq;
    logic       init_del;
    logic       enq_rd;
    logic       enq_shift;
    logic       enq_put;
    logic       del_step;
    logic       idx_inc;
    logic       cnt_dec;
    logic       emit;
    logic [2:0] emit_status;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       level_zero;
    logic       empty;
    logic       full;
    logic       idx_zero;
    logic       idx_last;
    logic       lvl_lt;
    logic       taken;
    logic       out_free;
  } sts_t;

endpackage

// ----- hw/rtl/spqr_dp.sv -----
// ----------------------------------------------------------------------------
// spqr_dp
// Datapath: entry memory, walk index, fill count, request and result
// registers.
// ----------------------------------------------------------------------------
module spqr_dp import spqr_pkg::*; #(
  parameter int CAPACITY = 16,
  parameter int KEY_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [1:0]  req_type,
  input  logic [31:0] user_key,
  input  logic [1:0]  user_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [31:0] out_key,
  output logic [1:0]  out_level
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = KEY_BITS + 2;

  logic [EW-1:0]       mem [CAPACITY];
  logic [EW-1:0]       rd_data;
  logic [EW-1:0]       wr_data;
  logic [EW-1:0]       cap_entry;
  logic [AW-1:0]       idx;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;
  logic                wr_en;
  logic [CW-1:0]       count;
  logic [1:0]          req_r;
  logic [1:0]          level_r;
  logic [KEY_BITS-1:0] key_r;
  logic [KEY_BITS-1:0] key_in;
  logic [63:0]         key_wide;
  logic [63:0]         cap_key_wide;
  logic                found;
  logic                hit;

  assign key_wide     = 64'(user_key);
  assign key_in       = key_wide[KEY_BITS-1:0];
  assign cap_key_wide = 64'(cap_entry[EW-1:2]);

  assign hit = (req_r == REQ_DEQ) || (rd_data[EW-1:2] == key_r);

  always_comb begin
    rd_addr = cmd.enq_rd ? idx - AW'(1) : idx;
    wr_en   = cmd.enq_shift | cmd.enq_put | (cmd.del_step & found);
    wr_addr = cmd.del_step ? idx - AW'(1) : idx;
    wr_data = cmd.enq_put ? {key_r, level_r} : rd_data;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    sts.req        = req_r;
    sts.level_zero = (level_r == 2'd0);
    sts.empty      = (count == '0);
    sts.full       = (count == CW'(CAPACITY));
    sts.idx_zero   = (idx == '0);
    sts.idx_last   = ((CW'(idx) + CW'(1)) == count);
    sts.lvl_lt     = (rd_data[1:0] < level_r);
    sts.taken      = found | hit;
    sts.out_free   = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.enq_put) begin
        count <= count + CW'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CW'(1);
      end
      if (cmd.load) begin
        found <= 1'b0;
      end else if (cmd.del_step && hit) begin
        found <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= req_type;
      key_r   <= key_in;
      level_r <= user_level;
    end
    if (cmd.init_enq) begin
      idx <= count[AW-1:0];
    end else if (cmd.init_del) begin
      idx <= '0;
    end else if (cmd.enq_shift) begin
      idx <= idx - AW'(1);
    end else if (cmd.idx_inc) begin
      idx <= idx + AW'(1);
    end
    if (cmd.del_step && !found && hit) begin
      cap_entry <= rd_data;
    end
    if (cmd.emit) begin
      status    <= cmd.emit_status;
      out_key   <= found ? cap_key_wide[31:0] : 32'd0;
      out_level <= found ? cap_entry[1:0] : 2'd0;
    end
  end

endmodule

// ----- hw/rtl/spqr_ctrl.sv -----
// ----------------------------------------------------------------------------
// spqr_ctrl
// Controller: decodes a request and sequences the entry walk.
// ----------------------------------------------------------------------------
module spqr_ctrl import spqr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ENQ_CHK,
    S_ENQ_EV,
    S_DEL_RD,
    S_DEL_EV,
    S_EMIT
  } state_t;

  state_t     state;
  logic [2:0] res_status;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_status <= ST_INVALID;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          case (sts.req)
            REQ_ENQ: begin
              if (sts.level_zero) begin
                res_status <= ST_INVALID;
                state      <= S_EMIT;
              end else if (sts.full) begin
                res_status <= ST_FULL;
                state      <= S_EMIT;
              end else begin
                state <= S_ENQ_CHK;
              end
            end
            REQ_DEQ, REQ_REM: begin
              if (sts.empty) begin
                res_status <= ST_EMPTY;
                state      <= S_EMIT;
              end else begin
                state <= S_DEL_RD;
              end
            end
            default: begin
              res_status <= ST_INVALID;
              state      <= S_EMIT;
            end
          endcase
        end
        S_ENQ_CHK: begin
          if (sts.idx_zero) begin
            res_status <= ST_QUEUED;
            state      <= S_EMIT;
          end else begin
            state <= S_ENQ_EV;
          end
        end
        S_ENQ_EV: begin
          if (sts.lvl_lt) begin
            state <= S_ENQ_CHK;
          end else begin
            res_status <= ST_QUEUED;
            state      <= S_EMIT;
          end
        end
        S_DEL_RD: begin
          state <= S_DEL_EV;
        end
        S_DEL_EV: begin
          if (sts.idx_last) begin
            if (!sts.taken) begin
              res_status <= ST_NOTFOUND;
            end else if (sts.req == REQ_DEQ) begin
              res_status <= ST_DEQUEUED;
            end else begin
              res_status <= ST_REMOVED;
            end
            state <= S_EMIT;
          end else begin
            state <= S_DEL_RD;
          end
        end
        S_EMIT: begin
          if (sts.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd             = '0;
    cmd.emit_status = res_status;
    case (state)
      S_IDLE: begin
        cmd.load = in_valid;
      end
      S_DECODE: begin
        cmd.init_enq = (sts.req == REQ_ENQ);
        cmd.init_del = (sts.req != REQ_ENQ);
      end
      S_ENQ_CHK: begin
        cmd.enq_rd  = !sts.idx_zero;
        cmd.enq_put = sts.idx_zero;
      end
      S_ENQ_EV: begin
        cmd.enq_shift = sts.lvl_lt;
        cmd.enq_put   = !sts.lvl_lt;
      end
      S_DEL_EV: begin
        cmd.del_step = 1'b1;
        cmd.idx_inc  = !sts.idx_last;
        cmd.cnt_dec  = sts.idx_last && sts.taken;
      end
      S_EMIT: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- hw/rtl/stable_priority_queue_with_remove.sv -----
// ----------------------------------------------------------------------------
// stable_priority_queue_with_remove
// Ordered queue of keyed entries with levels 1..3; enqueue, dequeue head and
// remove by key.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: in_valid/in_stall with req_type, user_key, user_level.
//   A request is taken when in_valid is high and in_stall is low.
//   Result channel: out_valid/out_stall with status, out_key, out_level.
//   Every request gives exactly one result.
//   One request is in work at a time; entries live in a memory with one
//   read and one write port that the controller walks entry by entry, each
//   in a read step and then a move step. Enqueue walks from the tail past the
//   entries behind the new one; dequeue and remove walk every entry held.
//   Rejected requests (empty, full, invalid level, bad type) skip the walk.
//   Reset empties the queue at once; no clearing pass, memory past the fill
//   count is never used.
//   A stalled result holds; the controller waits with the next result until
//   the output register is free, and takes no new request meanwhile.
// ----------------------------------------------------------------------------
module stable_priority_queue_with_remove import spqr_pkg::*; #(
  parameter int CAPACITY = 16,
  parameter int KEY_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [31:0] user_key,
  input  logic [1:0]  user_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [31:0] out_key,
  output logic [1:0]  out_level
);

  cmd_t cmd;
  sts_t sts;

  spqr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  spqr_dp #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .req_type   (req_type),
    .user_key   (user_key),
    .user_level (user_level),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .out_key    (out_key),
    .out_level  (out_level)
  );

endmodule

// ----- hw/rtl/spqr_checker.sv -----
// ----------------------------------------------------------------------------
// spqr_checker
// Port-level checks on the queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "stable_priority_queue_with_remove_assert.svh"

module spqr_checker import spqr_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  status,
  input logic [31:0] out_key,
  input logic [1:0]  out_level
);

  logic [36:0] res_bits;
  logic        out_held;
  logic        in_take;
  logic        res_taken;
  logic        taken_out;
  logic        bare_out;
  logic        pay_zero;

  assign res_bits  = {status, out_key, out_level};
  assign out_held  = out_valid && out_stall;
  assign in_take   = in_valid && !in_stall;
  assign res_taken = (status == ST_DEQUEUED) || (status == ST_REMOVED);
  assign taken_out = out_valid && res_taken;
  assign bare_out  = out_valid && !res_taken;
  assign pay_zero  = (out_key == 32'd0) && (out_level == 2'd0);

  `SPQR_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(res_bits), "stalled result changed")

  `SPQR_ASSERT_NEXT(a_busy_after_req, in_take, in_stall, "second request taken while busy")

  `SPQR_ASSERT_NOW(a_no_payload, bare_out, pay_zero, "payload on a result without entry")

  `SPQR_ASSERT_NOW(a_taken_level, taken_out, out_level != 2'd0, "taken entry has level zero")

endmodule

bind stable_priority_queue_with_remove spqr_checker u_spqr_checker (.*);
